[hw/rtl/rw_pkg.sv]
// Shared constants, types and state encoding for the resampling wheel.
package rw_pkg;

  localparam int MAX_PARTICLES = 128;
  localparam int WEIGHT_BITS   = 32;
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int COUNT_W       = $clog2(MAX_PARTICLES + 1);
  localparam int BETA_W        = WEIGHT_BITS + 2;
  localparam int FRAC_W        = 16;
  localparam int PROD_W        = FRAC_W + WEIGHT_BITS;
  localparam int STEP_W        = COUNT_W + 2;
  localparam int KIND_W        = 2;
  localparam int CFG_W         = 8;
  localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(100);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_DRAW  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_APPLY,
    S_READ,
    S_CMP,
    S_EMIT
  } state_t;

endpackage

[hw/rtl/rw_channels.sv]
// Valid/ready channel interfaces for the wheel's input and result streams.
interface rw_in_if
  import rw_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      kind;
  logic [WEIGHT_BITS-1:0] weight;
  logic [FRAC_W-1:0]      random_fraction;

  modport source (output valid, kind, weight, random_fraction, input ready);
  modport sink   (input valid, kind, weight, random_fraction, output ready);
endinterface

interface rw_out_if
  import rw_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] selected_index;
  logic             last_draw;

  modport source (output valid, selected_index, last_draw, input ready);
  modport sink   (input valid, selected_index, last_draw, output ready);
endinterface

[hw/rtl/resampling_wheel.sv]
// Resampling wheel: weight store, shared multiplier and sequenced wheel walk.
//
// Input channel in_ch carries transactions of three kinds: load a weight, start
// a round with a random offset, or draw one sample. Only draws give a result on
// out_ch: the selected particle index and a flag on the last draw of a round.
// cfg_we/cfg_data write particle_count; the user must do so only while the
// block is idle, which the block itself does not enforce.
// Sequencing: a load is taken in idle and in_ch.ready stays high. A start runs
// the multiply and apply states. A draw runs multiply, apply, then one RAM read
// and one 34-bit compare/subtract on beta for each of the k weights the wheel
// passes (at most 4*n), then emit. The 16x32 multiplier is shared between the
// start offset and the beta step.
//
// Reset clears the sequencer, counters, beta and max weight and sets
// particle_count to 100; the weight RAM is not cleared. The result sits in an
// output register: loads are still taken while it waits, but a following draw
// holds in its final state until out_ch.ready takes the pending result.
module resampling_wheel
  import rw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  rw_in_if.sink            in_ch,
  rw_out_if.source         out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [WEIGHT_BITS-1:0] weight_store [MAX_PARTICLES];
  logic [WEIGHT_BITS-1:0] rdata;

  logic [CFG_W-1:0]       particle_count;
  logic [WEIGHT_BITS-1:0] weight_peak;
  logic [COUNT_W-1:0]     load_pointer;
  logic [IDX_W-1:0]       wheel_index;
  logic [BETA_W-1:0]      beta_sum;
  logic [COUNT_W-1:0]     draw_count;
  logic [STEP_W-1:0]      steps;
  logic [FRAC_W-1:0]      frac;
  logic                   is_draw;
  logic [PROD_W-1:0]      product;

  logic                   in_acc;
  logic [COUNT_W-1:0]     n_eff;
  logic [STEP_W-1:0]      limit;
  logic [WEIGHT_BITS-1:0] mul_b;
  logic [BETA_W:0]        beta_add;
  logic [BETA_W-2:0]      inc;
  logic [COUNT_W-1:0]     wheel_inc;
  logic                   walk_on;
  logic                   out_free;
  logic [COUNT_W-1:0]     draw_inc;
  logic                   last;

  localparam logic [BETA_W-1:0] BETA_MAX = '1;

  assign in_acc = in_ch.valid && in_ch.ready;

  // Clamp the configured count to [1, MAX_PARTICLES].
  always_comb begin
    if (particle_count == '0) begin
      n_eff = COUNT_W'(1);
    end else if (COUNT_W'(particle_count) > COUNT_W'(MAX_PARTICLES)) begin
      n_eff = COUNT_W'(MAX_PARTICLES);
    end else begin
      n_eff = COUNT_W'(particle_count);
    end
  end

  assign limit     = {n_eff, 2'b00};
  assign mul_b     = is_draw ? weight_peak : WEIGHT_BITS'(n_eff - COUNT_W'(1));
  assign inc       = product[PROD_W-1:FRAC_W-1];
  assign beta_add  = {1'b0, beta_sum} + (BETA_W+1)'(inc);
  assign wheel_inc = COUNT_W'(wheel_index) + COUNT_W'(1);
  assign walk_on   = (steps < limit) && ({2'b00, rdata} < beta_sum);
  assign out_free  = !out_ch.valid || out_ch.ready;
  assign draw_inc  = draw_count + COUNT_W'(1);
  assign last      = (draw_inc >= n_eff);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && (in_ch.kind == KIND_START || in_ch.kind == KIND_DRAW)) begin
          state_next = S_MUL;
        end
      end
      S_MUL:   state_next = S_APPLY;
      S_APPLY: state_next = is_draw ? S_READ : S_IDLE;
      S_READ:  state_next = S_CMP;
      S_CMP:   state_next = walk_on ? S_READ : S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ch.ready = (state == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      particle_count <= COUNT_RESET;
    end else if (cfg_we) begin
      particle_count <= cfg_data;
    end
  end

  // Weight RAM: one write port, one registered read port at the wheel.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc && in_ch.kind == KIND_LOAD &&
        load_pointer < COUNT_W'(MAX_PARTICLES)) begin
      weight_store[load_pointer[IDX_W-1:0]] <= in_ch.weight;
    end
    rdata <= weight_store[wheel_index];
  end

  // Shared multiplier, registered.
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      product <= PROD_W'(frac) * PROD_W'(mul_b);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc) begin
      frac    <= in_ch.random_fraction;
      is_draw <= (in_ch.kind == KIND_DRAW);
    end
  end

  // Wheel control and beta datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_peak  <= '0;
      load_pointer <= '0;
      wheel_index  <= '0;
      beta_sum     <= '0;
      draw_count   <= '0;
      steps        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && in_ch.kind == KIND_LOAD &&
              load_pointer < COUNT_W'(MAX_PARTICLES)) begin
            load_pointer <= load_pointer + COUNT_W'(1);
            if (in_ch.weight > weight_peak) begin
              weight_peak <= in_ch.weight;
            end
          end
        end
        S_APPLY: begin
          if (is_draw) begin
            beta_sum <= (beta_add > (BETA_W+1)'(BETA_MAX)) ? BETA_MAX
                                                           : beta_add[BETA_W-1:0];
            if (COUNT_W'(wheel_index) >= n_eff) begin
              wheel_index <= '0;
            end
            steps <= '0;
          end else begin
            wheel_index <= product[FRAC_W +: IDX_W];
            beta_sum    <= '0;
            draw_count  <= '0;
          end
        end
        S_CMP: begin
          if (walk_on) begin
            beta_sum    <= beta_sum - BETA_W'(rdata);
            wheel_index <= (wheel_inc >= n_eff) ? '0 : wheel_inc[IDX_W-1:0];
            steps       <= steps + STEP_W'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (last) begin
              draw_count   <= '0;
              load_pointer <= '0;
              weight_peak  <= '0;
            end else begin
              draw_count <= draw_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_ch.selected_index <= wheel_index;
      out_ch.last_draw      <= last;
    end
  end

endmodule

[hw/rtl/rw_checker.sv]
// Port-level checks on the resampling wheel, bound to the top level.
module rw_checker
  import rw_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [KIND_W-1:0] in_kind,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] out_index,
  input logic             out_last
);

  // No result straight after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A draw keeps the block busy on the next cycle.
  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_kind == KIND_DRAW) |=> !in_ready)
    else $error("input ready right after a draw transaction");

  // A new result only appears out of the busy walk.
  a_result_from_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

  // Hold a stalled result.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_index) && $stable(out_last)))
    else $error("stalled result changed or dropped");

endmodule

bind resampling_wheel rw_checker u_rw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_kind   (in_ch.kind),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_index (out_ch.selected_index),
  .out_last  (out_ch.last_draw)
);
